### design/qau_pkg.sv
package qau_pkg;

	// number format
	localparam int FRAC_BITS = 14;
	localparam int PROD_W = 32;
	localparam int SUM_W = 36;
	localparam int SQ_W = 33;
	localparam int LEN_W = 17;
	localparam int QW = FRAC_BITS + 1;
	localparam int SQ_N = 17;

	typedef logic signed [15:0] q_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// operation codes
	localparam logic [2:0] F_QMUL = 3'd0;
	localparam logic [2:0] F_QVMUL = 3'd1;
	localparam logic [2:0] F_SCALE = 3'd2;
	localparam logic [2:0] F_CONJ = 3'd3;
	localparam logic [2:0] F_NORM = 3'd4;
	localparam logic [2:0] F_MAT = 3'd5;
	localparam logic [2:0] F_EQ = 3'd6;

	// symmetric product slots
	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_WW = 3;
	localparam int P_XY = 4;
	localparam int P_XZ = 5;
	localparam int P_YZ = 6;
	localparam int P_WX = 7;
	localparam int P_WY = 8;
	localparam int P_WZ = 9;
	localparam int NSP = 10;

	localparam sum_t ONE = sum_t'(1) <<< (2 * FRAC_BITS);

	typedef struct packed {
		logic [2:0] func;
		q_t [3:0] a;
		q_t [3:0] b;
		q_t scale;
	} in_t;

	// payload carried alongside the normalize pipe
	typedef struct packed {
		q_t [8:0] res;
		q_t [3:0] comp;
		logic eq;
		logic sat;
		logic norm;
	} side_t;

	typedef struct packed {
		logic sat;
		q_t val;
	} rnd_t;

	function automatic prod_t mul(input q_t x, input q_t y);
		prod_t p;
		p = x * y;
		return p;
	endfunction

	function automatic sum_t ext(input prod_t p);
		return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	// round half up to FRAC_BITS fraction bits, then clamp
	function automatic rnd_t rnd(input sum_t v);
		logic signed [SUM_W:0] t;
		logic signed [SUM_W-FRAC_BITS:0] q;
		rnd_t r;
		t = (SUM_W+1)'(v) + ((SUM_W+1)'(1) <<< (FRAC_BITS - 1));
		q = (SUM_W-FRAC_BITS+1)'(t >>> FRAC_BITS);
		if (q > (SUM_W-FRAC_BITS+1)'(32767)) begin
			r = '{sat: 1'b1, val: 16'sh7fff};
		end else if (q < -(SUM_W-FRAC_BITS+1)'(32768)) begin
			r = '{sat: 1'b1, val: 16'sh8000};
		end else begin
			r = '{sat: 1'b0, val: q[15:0]};
		end
		return r;
	endfunction

	function automatic rnd_t neg_sat(input q_t v);
		rnd_t r;
		if (v == 16'sh8000) begin
			r = '{sat: 1'b1, val: 16'sh7fff};
		end else begin
			r = '{sat: 1'b0, val: -v};
		end
		return r;
	endfunction

endpackage

### design/qau_in_if.sv
interface qau_in_if;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [15:0] a_x;
	logic signed [15:0] a_y;
	logic signed [15:0] a_z;
	logic signed [15:0] a_w;
	logic signed [15:0] b_x;
	logic signed [15:0] b_y;
	logic signed [15:0] b_z;
	logic signed [15:0] b_w;
	logic signed [15:0] scale;

	modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale,
		input ready);
	modport sink (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale,
		output ready);
endinterface

### design/qau_out_if.sv
interface qau_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] r0;
	logic signed [15:0] r1;
	logic signed [15:0] r2;
	logic signed [15:0] r3;
	logic signed [15:0] r4;
	logic signed [15:0] r5;
	logic signed [15:0] r6;
	logic signed [15:0] r7;
	logic signed [15:0] r8;
	logic equal;
	logic error;
	logic saturated;

	modport source (output valid, r0, r1, r2, r3, r4, r5, r6, r7, r8, equal, error,
		saturated, input ready);
	modport sink (input valid, r0, r1, r2, r3, r4, r5, r6, r7, r8, equal, error,
		saturated, output ready);
endinterface

### design/qau_front.sv
module qau_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input qau_pkg::in_t in_data,
	output logic out_valid,
	output logic [qau_pkg::SQ_W-1:0] sumsq,
	output qau_pkg::side_t side
);

	qau_pkg::q_t [3:0] hb;
	qau_pkg::prod_t hp [16];
	qau_pkg::prod_t sp [qau_pkg::NSP];

	logic v_s1, v_s2, v_s3;
	logic [2:0] func_s1, func_s2;
	qau_pkg::q_t [3:0] a_s1, a_s2;
	logic eq_s1, eq_s2;
	qau_pkg::prod_t hp_s1 [16];
	qau_pkg::prod_t sp_s1 [qau_pkg::NSP];
	qau_pkg::sum_t h_s2 [4];
	qau_pkg::sum_t m_s2 [9];
	logic [qau_pkg::SQ_W-1:0] sumsq_s2, sumsq_s3;
	qau_pkg::side_t side_s3;
	qau_pkg::side_t side_n;

	// second operand for the hamilton products
	always_comb begin
		case (in_data.func)
			qau_pkg::F_QVMUL: hb = {16'sd0, in_data.b[2], in_data.b[1], in_data.b[0]};
			qau_pkg::F_SCALE: hb = {in_data.scale, 16'sd0, 16'sd0, 16'sd0};
			default: hb = in_data.b;
		endcase
	end

	// products, ordered so each result sums four of them
	always_comb begin
		hp[0] = qau_pkg::mul(in_data.a[0], hb[3]);
		hp[1] = qau_pkg::mul(in_data.a[3], hb[0]);
		hp[2] = qau_pkg::mul(in_data.a[1], hb[2]);
		hp[3] = qau_pkg::mul(in_data.a[2], hb[1]);
		hp[4] = qau_pkg::mul(in_data.a[1], hb[3]);
		hp[5] = qau_pkg::mul(in_data.a[3], hb[1]);
		hp[6] = qau_pkg::mul(in_data.a[2], hb[0]);
		hp[7] = qau_pkg::mul(in_data.a[0], hb[2]);
		hp[8] = qau_pkg::mul(in_data.a[2], hb[3]);
		hp[9] = qau_pkg::mul(in_data.a[3], hb[2]);
		hp[10] = qau_pkg::mul(in_data.a[0], hb[1]);
		hp[11] = qau_pkg::mul(in_data.a[1], hb[0]);
		hp[12] = qau_pkg::mul(in_data.a[3], hb[3]);
		hp[13] = qau_pkg::mul(in_data.a[0], hb[0]);
		hp[14] = qau_pkg::mul(in_data.a[1], hb[1]);
		hp[15] = qau_pkg::mul(in_data.a[2], hb[2]);
		sp[qau_pkg::P_XX] = qau_pkg::mul(in_data.a[0], in_data.a[0]);
		sp[qau_pkg::P_YY] = qau_pkg::mul(in_data.a[1], in_data.a[1]);
		sp[qau_pkg::P_ZZ] = qau_pkg::mul(in_data.a[2], in_data.a[2]);
		sp[qau_pkg::P_WW] = qau_pkg::mul(in_data.a[3], in_data.a[3]);
		sp[qau_pkg::P_XY] = qau_pkg::mul(in_data.a[0], in_data.a[1]);
		sp[qau_pkg::P_XZ] = qau_pkg::mul(in_data.a[0], in_data.a[2]);
		sp[qau_pkg::P_YZ] = qau_pkg::mul(in_data.a[1], in_data.a[2]);
		sp[qau_pkg::P_WX] = qau_pkg::mul(in_data.a[3], in_data.a[0]);
		sp[qau_pkg::P_WY] = qau_pkg::mul(in_data.a[3], in_data.a[1]);
		sp[qau_pkg::P_WZ] = qau_pkg::mul(in_data.a[3], in_data.a[2]);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= in_data.func;
			a_s1 <= in_data.a;
			eq_s1 <= (in_data.func == qau_pkg::F_EQ) && (in_data.a == in_data.b);
			hp_s1 <= hp;
			sp_s1 <= sp;
		end
	end

	// stage 2: sums
	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			a_s2 <= a_s1;
			eq_s2 <= eq_s1;
			for (int j = 0; j < 3; j++) begin
				h_s2[j] <= qau_pkg::ext(hp_s1[4*j]) + qau_pkg::ext(hp_s1[4*j+1])
					+ qau_pkg::ext(hp_s1[4*j+2]) - qau_pkg::ext(hp_s1[4*j+3]);
			end
			h_s2[3] <= qau_pkg::ext(hp_s1[12]) - qau_pkg::ext(hp_s1[13])
				- qau_pkg::ext(hp_s1[14]) - qau_pkg::ext(hp_s1[15]);
			m_s2[0] <= (qau_pkg::ext(sp_s1[qau_pkg::P_XZ])
				- qau_pkg::ext(sp_s1[qau_pkg::P_WY])) <<< 1;
			m_s2[1] <= (qau_pkg::ext(sp_s1[qau_pkg::P_YZ])
				+ qau_pkg::ext(sp_s1[qau_pkg::P_WX])) <<< 1;
			m_s2[2] <= qau_pkg::ONE - ((qau_pkg::ext(sp_s1[qau_pkg::P_XX])
				+ qau_pkg::ext(sp_s1[qau_pkg::P_YY])) <<< 1);
			m_s2[3] <= (qau_pkg::ext(sp_s1[qau_pkg::P_XY])
				+ qau_pkg::ext(sp_s1[qau_pkg::P_WZ])) <<< 1;
			m_s2[4] <= qau_pkg::ONE - ((qau_pkg::ext(sp_s1[qau_pkg::P_XX])
				+ qau_pkg::ext(sp_s1[qau_pkg::P_ZZ])) <<< 1);
			m_s2[5] <= (qau_pkg::ext(sp_s1[qau_pkg::P_YZ])
				- qau_pkg::ext(sp_s1[qau_pkg::P_WX])) <<< 1;
			m_s2[6] <= qau_pkg::ONE - ((qau_pkg::ext(sp_s1[qau_pkg::P_YY])
				+ qau_pkg::ext(sp_s1[qau_pkg::P_ZZ])) <<< 1);
			m_s2[7] <= (qau_pkg::ext(sp_s1[qau_pkg::P_XY])
				- qau_pkg::ext(sp_s1[qau_pkg::P_WZ])) <<< 1;
			m_s2[8] <= (qau_pkg::ext(sp_s1[qau_pkg::P_XZ])
				+ qau_pkg::ext(sp_s1[qau_pkg::P_WY])) <<< 1;
			// squares are never negative
			sumsq_s2 <= qau_pkg::SQ_W'(sp_s1[qau_pkg::P_XX][qau_pkg::PROD_W-1:0])
				+ qau_pkg::SQ_W'(sp_s1[qau_pkg::P_YY][qau_pkg::PROD_W-1:0])
				+ qau_pkg::SQ_W'(sp_s1[qau_pkg::P_ZZ][qau_pkg::PROD_W-1:0])
				+ qau_pkg::SQ_W'(sp_s1[qau_pkg::P_WW][qau_pkg::PROD_W-1:0]);
		end
	end

	// stage 3 logic: round, clamp and select by operation
	always_comb begin
		qau_pkg::rnd_t rr;
		side_n = '0;
		side_n.comp = a_s2;
		rr = '0;
		case (func_s2)
			qau_pkg::F_QMUL, qau_pkg::F_QVMUL, qau_pkg::F_SCALE: begin
				for (int j = 0; j < 4; j++) begin
					rr = qau_pkg::rnd(h_s2[j]);
					side_n.res[j] = rr.val;
					side_n.sat = side_n.sat | rr.sat;
				end
			end
			qau_pkg::F_CONJ: begin
				for (int j = 0; j < 3; j++) begin
					rr = qau_pkg::neg_sat(a_s2[j]);
					side_n.res[j] = rr.val;
					side_n.sat = side_n.sat | rr.sat;
				end
				side_n.res[3] = a_s2[3];
			end
			qau_pkg::F_NORM: begin
				side_n.norm = 1'b1;
			end
			qau_pkg::F_MAT: begin
				for (int j = 0; j < 9; j++) begin
					rr = qau_pkg::rnd(m_s2[j]);
					side_n.res[j] = rr.val;
					side_n.sat = side_n.sat | rr.sat;
				end
			end
			qau_pkg::F_EQ: begin
				side_n.eq = eq_s2;
			end
			default: begin
				side_n.eq = 1'b0;
			end
		endcase
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_n;
			sumsq_s3 <= sumsq_s2;
		end
	end

	assign out_valid = v_s3;
	assign sumsq = sumsq_s3;
	assign side = side_s3;

endmodule

### design/qau_sqrt.sv
module qau_sqrt (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [qau_pkg::SQ_W-1:0] sumsq,
	input qau_pkg::side_t in_side,
	output logic out_valid,
	output logic [qau_pkg::LEN_W-1:0] len,
	output qau_pkg::side_t out_side
);

	localparam int RAD_W = 2 * qau_pkg::SQ_N;
	localparam int REM_W = qau_pkg::LEN_W + 1;

	logic v_s [qau_pkg::SQ_N];
	logic [REM_W-1:0] rem_s [qau_pkg::SQ_N];
	logic [qau_pkg::LEN_W-1:0] root_s [qau_pkg::SQ_N];
	logic [RAD_W-1:0] rad_s [qau_pkg::SQ_N];
	qau_pkg::side_t side_s [qau_pkg::SQ_N];

	// one root bit per stage, two radicand bits consumed
	for (genvar k = 0; k < qau_pkg::SQ_N; k++) begin : g_step
		logic v_i;
		logic [REM_W-1:0] rem_i;
		logic [qau_pkg::LEN_W-1:0] root_i;
		logic [RAD_W-1:0] rad_i;
		qau_pkg::side_t side_i;
		logic [REM_W+1:0] acc;
		logic [REM_W+1:0] trial;

		if (k == 0) begin : g_first
			assign v_i = in_valid;
			assign rem_i = '0;
			assign root_i = '0;
			assign rad_i = RAD_W'(sumsq);
			assign side_i = in_side;
		end else begin : g_next
			assign v_i = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i = rad_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign acc = {rem_i, rad_i[RAD_W-1-2*k -: 2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (acc >= trial) begin
					rem_s[k] <= REM_W'(acc - trial);
					root_s[k] <= {root_i[qau_pkg::LEN_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= acc[REM_W-1:0];
					root_s[k] <= {root_i[qau_pkg::LEN_W-2:0], 1'b0};
				end
				rad_s[k] <= rad_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[qau_pkg::SQ_N-1];
	assign len = root_s[qau_pkg::SQ_N-1];
	assign out_side = side_s[qau_pkg::SQ_N-1];

endmodule

### design/qau_div.sv
module qau_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [qau_pkg::LEN_W-1:0] in_len,
	input qau_pkg::side_t in_side,
	output logic out_valid,
	output logic [3:0][qau_pkg::QW-1:0] quo,
	output logic [qau_pkg::LEN_W-1:0] out_len,
	output qau_pkg::side_t out_side
);

	localparam int QW = qau_pkg::QW;
	localparam int DW = qau_pkg::LEN_W + 1;
	localparam int NUM_W = 16 + QW + 1;

	// prep stage: numerator = |c| * 2^(FRAC_BITS+1) + len, divisor = 2 * len
	logic v_p;
	logic [3:0][DW-1:0] rem_p;
	logic [3:0][QW-1:0] lo_p;
	logic [DW-1:0] d_p;
	logic [qau_pkg::LEN_W-1:0] len_p;
	qau_pkg::side_t side_p;
	logic [3:0][DW-1:0] rem_n;
	logic [3:0][QW-1:0] lo_n;

	always_comb begin
		logic [15:0] c;
		logic [15:0] mag;
		logic [NUM_W-1:0] num;
		for (int j = 0; j < 4; j++) begin
			c = in_side.comp[j];
			mag = c[15] ? 16'(~c + 16'd1) : c;
			num = {1'b0, mag, {QW{1'b0}}} + NUM_W'(in_len);
			rem_n[j] = DW'(num[NUM_W-1:QW]);
			lo_n[j] = num[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_p <= rem_n;
			lo_p <= lo_n;
			d_p <= {in_len, 1'b0};
			len_p <= in_len;
			side_p <= in_side;
		end
	end

	logic v_s [QW];
	logic [3:0][DW-1:0] rem_s [QW];
	logic [3:0][QW-1:0] q_s [QW];
	logic [3:0][QW-1:0] lo_s [QW];
	logic [DW-1:0] d_s [QW];
	logic [qau_pkg::LEN_W-1:0] len_s [QW];
	qau_pkg::side_t side_s [QW];

	// one quotient bit per stage in each of the four lanes
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic v_i;
		logic [3:0][DW-1:0] rem_i;
		logic [3:0][QW-1:0] q_i;
		logic [3:0][QW-1:0] lo_i;
		logic [DW-1:0] d_i;
		logic [qau_pkg::LEN_W-1:0] len_i;
		qau_pkg::side_t side_i;
		logic [3:0][DW-1:0] rem_o;
		logic [3:0][QW-1:0] q_o;

		if (k == 0) begin : g_first
			assign v_i = v_p;
			assign rem_i = rem_p;
			assign q_i = '0;
			assign lo_i = lo_p;
			assign d_i = d_p;
			assign len_i = len_p;
			assign side_i = side_p;
		end else begin : g_next
			assign v_i = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign q_i = q_s[k-1];
			assign lo_i = lo_s[k-1];
			assign d_i = d_s[k-1];
			assign len_i = len_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			logic [DW:0] trial;
			for (int j = 0; j < 4; j++) begin
				trial = {rem_i[j], lo_i[j][QW-1-k]};
				if (trial >= {1'b0, d_i}) begin
					rem_o[j] = DW'(trial - {1'b0, d_i});
					q_o[j] = {q_i[j][QW-2:0], 1'b1};
				end else begin
					rem_o[j] = trial[DW-1:0];
					q_o[j] = {q_i[j][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_o;
				q_s[k] <= q_o;
				lo_s[k] <= lo_i;
				d_s[k] <= d_i;
				len_s[k] <= len_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo = q_s[QW-1];
	assign out_len = len_s[QW-1];
	assign out_side = side_s[QW-1];

endmodule

### design/quaternion_arithmetic_unit.sv
// quaternion arithmetic unit, signed Q2.14
// din carries one operation per beat (func, quaternion a, quaternion or vector b,
// scale); dout carries one result beat per accepted input beat, in order:
// r0..r8, equal, error and saturated.
// an accepted input beat travels to its result on dout through:
// 3 front stages (products, sums, round/clamp), 17 square-root stages (one root
// bit each), 16 divider stages (setup plus one quotient bit each, four lanes) and
// the output register. every operation takes the same path, so order is kept.
// throughput is one beat per cycle while dout is not stalled; the depth of the square
// root and divider sets the latency, not the rate.
// when dout is stalled the whole pipe holds and din.ready drops in the same
// cycle; nothing is dropped or repeated, and a waiting result stays in the output
// register and no input beat enters until dout.ready is high.
// arst_n clears all valid bits; the pipe is empty and ready right after reset.
module quaternion_arithmetic_unit (
	input logic clk,
	input logic arst_n,
	qau_in_if.sink din,
	qau_out_if.source dout
);

	logic adv;
	qau_pkg::in_t in_data;

	logic f_valid;
	logic [qau_pkg::SQ_W-1:0] f_sumsq;
	qau_pkg::side_t f_side;

	logic s_valid;
	logic [qau_pkg::LEN_W-1:0] s_len;
	qau_pkg::side_t s_side;

	logic d_valid;
	logic [3:0][qau_pkg::QW-1:0] d_quo;
	logic [qau_pkg::LEN_W-1:0] d_len;
	qau_pkg::side_t d_side;

	logic vo_q;
	qau_pkg::q_t [8:0] res_q;
	logic eq_q, err_q, sat_q;
	qau_pkg::q_t [8:0] res_n;
	logic err_n;

	// whole pipe advances unless a result waits on a stalled output
	assign adv = !vo_q || dout.ready;
	assign din.ready = adv;

	assign in_data.func = din.func;
	assign in_data.a = {din.a_w, din.a_z, din.a_y, din.a_x};
	assign in_data.b = {din.b_w, din.b_z, din.b_y, din.b_x};
	assign in_data.scale = din.scale;

	qau_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(din.valid),
		.in_data(in_data),
		.out_valid(f_valid),
		.sumsq(f_sumsq),
		.side(f_side)
	);

	qau_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(f_valid),
		.sumsq(f_sumsq),
		.in_side(f_side),
		.out_valid(s_valid),
		.len(s_len),
		.out_side(s_side)
	);

	qau_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(s_valid),
		.in_len(s_len),
		.in_side(s_side),
		.out_valid(d_valid),
		.quo(d_quo),
		.out_len(d_len),
		.out_side(d_side)
	);

	// normalize result: signed quotient, or pass-through on zero length
	always_comb begin
		res_n = d_side.res;
		err_n = 1'b0;
		if (d_side.norm) begin
			if (d_len == '0) begin
				err_n = 1'b1;
				for (int j = 0; j < 4; j++) begin
					res_n[j] = d_side.comp[j];
				end
			end else begin
				for (int j = 0; j < 4; j++) begin
					if (d_side.comp[j][15]) begin
						res_n[j] = 16'(-{1'b0, d_quo[j]});
					end else begin
						res_n[j] = 16'({1'b0, d_quo[j]});
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (adv) begin
			vo_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
			eq_q <= d_side.eq;
			err_q <= err_n;
			sat_q <= d_side.sat;
		end
	end

	assign dout.valid = vo_q;
	assign dout.r0 = res_q[0];
	assign dout.r1 = res_q[1];
	assign dout.r2 = res_q[2];
	assign dout.r3 = res_q[3];
	assign dout.r4 = res_q[4];
	assign dout.r5 = res_q[5];
	assign dout.r6 = res_q[6];
	assign dout.r7 = res_q[7];
	assign dout.r8 = res_q[8];
	assign dout.equal = eq_q;
	assign dout.error = err_q;
	assign dout.saturated = sat_q;

	// a zero-length normalize never reports clamping
	a_err_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && err_q |-> !sat_q)
		else $error("error and saturated both set");

	// an equality result carries all-zero components
	a_eq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && eq_q |-> (res_q == '0) && !sat_q)
		else $error("equal beat with nonzero components");

	// equal and error come from different operations
	a_eq_err: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> !(eq_q && err_q))
		else $error("equal and error both set");

endmodule
